// ===== hw/rtl/ihu_pkg.sv =====
// Shared constants and types for the indexed max-heap block.
package ihu_pkg;
  localparam int unsigned MaxWorkers = 1024;
  localparam int unsigned AddrW      = $clog2(MaxWorkers);
  localparam int unsigned CountW     = AddrW + 1;
  localparam int unsigned WorkerW    = 10;
  localparam int unsigned ValueW     = 32;

  localparam logic [1:0] CmdClear  = 2'd0;
  localparam logic [1:0] CmdLoad   = 2'd1;
  localparam logic [1:0] CmdUpdate = 2'd2;
  localparam logic [1:0] CmdUnused = 2'd3;

  typedef enum logic [1:0] {
    StatusOk        = 2'd0,
    StatusFull      = 2'd1,
    StatusNotLoaded = 2'd2
  } status_e;

  typedef struct packed {
    logic signed [ValueW-1:0] value;
    logic [AddrW-1:0]         worker;
  } node_t;
endpackage

// ===== hw/rtl/ihu_in_if.sv =====
// Input item channel: command, worker and amount.
interface ihu_in_if;
  logic                               valid;
  logic                               ready;
  logic [1:0]                         command;
  logic [ihu_pkg::WorkerW-1:0]        worker;
  logic signed [ihu_pkg::ValueW-1:0]  amount;
  modport source (output valid, command, worker, amount, input ready);
  modport sink (input valid, command, worker, amount, output ready);
endinterface

// ===== hw/rtl/ihu_out_if.sv =====
// Result item channel: current maximum and status.
interface ihu_out_if;
  logic                               valid;
  logic                               ready;
  logic signed [ihu_pkg::ValueW-1:0]  max_value;
  logic [1:0]                         status;
  modport source (output valid, max_value, status, input ready);
  modport sink (input valid, max_value, status, output ready);
endinterface

// ===== hw/rtl/ihu_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read.
module ihu_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;
endmodule

// ===== hw/rtl/indexed_max_heap_update.sv =====
// Top level: indexed binary max-heap with a sequenced sift unit.
// Usage:
//   in_i carries one command per item (clear, load, update); out_o returns
//   one result per item: the heap maximum after the item (0 when empty)
//   and a status (ok, heap full on load, worker not loaded on update).
// Timing:
//   Items are handled one at a time; in_i.ready is high only when idle.
//   Clear goes straight to the root read. Load sifts the new node up; update
//   sifts the node up for a positive amount, else down; either way the
//   walk is bounded by the heap depth (10 levels for 1024 workers). The
//   sift loop is set by the single read port of the heap memory: one
//   parent read, or one or two child reads, per level.
// Reset:
//   rst_ni clears the worker count and the sequencer; the memories are not
//   cleared since only entries below the count are ever used.
// Backpressure:
//   The result stays on out_o until taken; no new item is accepted until
//   then.
module indexed_max_heap_update (
  input  logic       clk_i,
  input  logic       rst_ni,
  ihu_in_if.sink     in_i,
  ihu_out_if.source  out_o
);
  localparam int unsigned AW = ihu_pkg::AddrW;
  localparam int unsigned CW = ihu_pkg::CountW;
  localparam int unsigned NW = $bits(ihu_pkg::node_t);

  localparam logic [3:0] SIdle  = 4'd0;
  localparam logic [3:0] SUp    = 4'd1;
  localparam logic [3:0] SUpCmp = 4'd2;
  localparam logic [3:0] SDn    = 4'd3;
  localparam logic [3:0] SDnL   = 4'd4;
  localparam logic [3:0] SDnR   = 4'd5;
  localparam logic [3:0] SDnCmp = 4'd6;
  localparam logic [3:0] SUpd1  = 4'd7;
  localparam logic [3:0] SUpd2  = 4'd8;
  localparam logic [3:0] SFin   = 4'd9;
  localparam logic [3:0] SRoot  = 4'd10;
  localparam logic [3:0] SRootW = 4'd11;
  localparam logic [3:0] SOut   = 4'd12;

  logic [3:0]            state_q, state_d;
  logic [CW-1:0]         cnt_q, cnt_d;
  logic [AW-1:0]         pos_q, pos_d;
  ihu_pkg::node_t        cur_q, cur_d;
  ihu_pkg::node_t        pick_q, pick_d;
  logic [AW-1:0]         pick_idx_q, pick_idx_d;
  logic signed [31:0]    amt_q, amt_d;
  logic signed [31:0]    max_q, max_d;
  ihu_pkg::status_e      stat_q, stat_d;

  logic                  h_we, p_we;
  logic [AW-1:0]         h_waddr, h_raddr, p_waddr, p_raddr;
  ihu_pkg::node_t        h_wdata, h_rdata;
  logic [AW-1:0]         p_wdata, p_rdata;
  logic [NW-1:0]         h_rraw;

  logic [AW+1:0]         left, right;
  logic [AW-1:0]         parent;
  logic [32:0]           sum;
  logic signed [31:0]    sat;

  ihu_ram #(.Width(NW), .Depth(ihu_pkg::MaxWorkers)) u_heap (
    .clk_i   (clk_i),
    .we_i    (h_we),
    .waddr_i (h_waddr),
    .wdata_i (h_wdata),
    .raddr_i (h_raddr),
    .rdata_o (h_rraw)
  );
  assign h_rdata = ihu_pkg::node_t'(h_rraw);

  ihu_ram #(.Width(AW), .Depth(ihu_pkg::MaxWorkers)) u_wpos (
    .clk_i   (clk_i),
    .we_i    (p_we),
    .waddr_i (p_waddr),
    .wdata_i (p_wdata),
    .raddr_i (p_raddr),
    .rdata_o (p_rdata)
  );

  assign left   = {1'b0, pos_q, 1'b1};
  assign right  = left + (AW+2)'(1);
  assign parent = (pos_q - AW'(1)) >> 1;
  assign sum    = {cur_q.value[31], cur_q.value} + {amt_q[31], amt_q};
  assign sat    = (sum[32] != sum[31]) ? {sum[32], {31{~sum[32]}}} : sum[31:0];

  assign in_i.ready      = (state_q == SIdle);
  assign out_o.valid     = (state_q == SOut);
  assign out_o.max_value = max_q;
  assign out_o.status    = stat_q;

  always_comb begin
    state_d    = state_q;
    cnt_d      = cnt_q;
    pos_d      = pos_q;
    cur_d      = cur_q;
    pick_d     = pick_q;
    pick_idx_d = pick_idx_q;
    amt_d      = amt_q;
    max_d      = max_q;
    stat_d     = stat_q;
    h_we       = 1'b0;
    h_waddr    = pos_q;
    h_wdata    = cur_q;
    h_raddr    = '0;
    p_we       = 1'b0;
    p_waddr    = cur_q.worker;
    p_wdata    = pos_q;
    p_raddr    = in_i.worker[AW-1:0];

    unique case (state_q)
      SIdle: begin
        if (in_i.valid) begin
          stat_d = ihu_pkg::StatusOk;
          amt_d  = in_i.amount;
          state_d = SRoot;
          if (in_i.command == ihu_pkg::CmdClear) begin
            cnt_d = '0;
          end else if (in_i.command == ihu_pkg::CmdLoad) begin
            if (cnt_q == CW'(ihu_pkg::MaxWorkers)) begin
              stat_d = ihu_pkg::StatusFull;
            end else begin
              pos_d        = cnt_q[AW-1:0];
              cur_d.value  = in_i.amount;
              cur_d.worker = cnt_q[AW-1:0];
              cnt_d        = cnt_q + CW'(1);
              state_d      = SUp;
            end
          end else if (in_i.command == ihu_pkg::CmdUpdate) begin
            if ({1'b0, in_i.worker} >= cnt_q) begin
              stat_d = ihu_pkg::StatusNotLoaded;
            end else begin
              state_d = SUpd1;
            end
          end
        end
      end
      SUpd1: begin
        pos_d   = ({1'b0, p_rdata} >= cnt_q) ? '0 : p_rdata;
        h_raddr = pos_d;
        state_d = SUpd2;
      end
      SUpd2: begin
        // the saturated sum lands in cur_q during the first sift cycle
        cur_d   = h_rdata;
        state_d = (amt_q > 0) ? SUp : SDn;
      end
      SUp: begin
        if (pos_q == '0) begin
          state_d = SFin;
        end else begin
          h_raddr = parent;
          state_d = SUpCmp;
        end
      end
      SUpCmp: begin
        if (cur_q.value > h_rdata.value) begin
          h_we    = 1'b1;
          h_wdata = h_rdata;
          p_we    = 1'b1;
          p_waddr = h_rdata.worker;
          pos_d   = parent;
          state_d = SUp;
        end else begin
          state_d = SFin;
        end
      end
      SDn: begin
        if ({1'b0, left} >= {2'b0, cnt_q}) begin
          state_d = SFin;
        end else begin
          h_raddr = left[AW-1:0];
          state_d = SDnL;
        end
      end
      SDnL: begin
        pick_d     = h_rdata;
        pick_idx_d = left[AW-1:0];
        if ({1'b0, right} < {2'b0, cnt_q}) begin
          h_raddr = right[AW-1:0];
          state_d = SDnR;
        end else begin
          state_d = SDnCmp;
        end
      end
      SDnR: begin
        if (h_rdata.value > pick_q.value) begin
          pick_d     = h_rdata;
          pick_idx_d = right[AW-1:0];
        end
        state_d = SDnCmp;
      end
      SDnCmp: begin
        if (cur_q.value >= pick_q.value) begin
          state_d = SFin;
        end else begin
          h_we    = 1'b1;
          h_wdata = pick_q;
          p_we    = 1'b1;
          p_waddr = pick_q.worker;
          pos_d   = pick_idx_q;
          state_d = SDn;
        end
      end
      SFin: begin
        h_we    = 1'b1;
        p_we    = 1'b1;
        state_d = SRoot;
      end
      SRoot: begin
        h_raddr = '0;
        state_d = SRootW;
      end
      SRootW: begin
        max_d   = (cnt_q != '0) ? h_rdata.value : '0;
        state_d = SOut;
      end
      SOut: begin
        if (out_o.ready) begin
          state_d = SIdle;
        end
      end
      default: state_d = SIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SIdle;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  // Update path: the fetched node is summed in the cycle after it lands in cur_q.
  logic upd_sum_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      upd_sum_q <= 1'b0;
    end else begin
      upd_sum_q <= (state_q == SUpd2);
    end
  end

  always_ff @(posedge clk_i) begin
    pos_q      <= pos_d;
    pick_q     <= pick_d;
    pick_idx_q <= pick_idx_d;
    amt_q      <= amt_d;
    max_q      <= max_d;
    stat_q     <= stat_d;
    if (upd_sum_q) begin
      cur_q.value  <= sat;
      cur_q.worker <= cur_q.worker;
    end else begin
      cur_q <= cur_d;
    end
  end
endmodule
